/* design/fcalu_pkg.sv */
// ----------------------------------------------------------------------------
// fcalu_pkg
// Shared types and constants for the GF(2^255-19) radix-2^51 field ALU.
// ----------------------------------------------------------------------------
package fcalu_pkg;

	localparam int LIMB_BITS = 51;
	localparam int FOLD      = 19;
	localparam int COL_W     = 118;
	localparam int PROD_W    = 113;

	localparam logic [55:0] BIAS0 = 56'h7FFFFFFFFFFED0;
	localparam logic [55:0] BIASN = 56'h7FFFFFFFFFFFF0;

	localparam logic [2:0] OP_MUL = 3'd0;
	localparam logic [2:0] OP_SQR = 3'd1;
	localparam logic [2:0] OP_ADD = 3'd2;
	localparam logic [2:0] OP_SUB = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_CAN = 3'd5;

	typedef logic [4:0][53:0]      fe_in_t;
	typedef logic [4:0][54:0]      fe_out_t;
	typedef logic [4:0][COL_W-1:0] col_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [53:0] a_limb0;
		logic [53:0] a_limb1;
		logic [53:0] a_limb2;
		logic [53:0] a_limb3;
		logic [53:0] a_limb4;
		logic [53:0] b_limb0;
		logic [53:0] b_limb1;
		logic [53:0] b_limb2;
		logic [53:0] b_limb3;
		logic [53:0] b_limb4;
		logic [7:0]  square_count;
	} req_t;

	typedef struct packed {
		logic [54:0] r_limb0;
		logic [54:0] r_limb1;
		logic [54:0] r_limb2;
		logic [54:0] r_limb3;
		logic [54:0] r_limb4;
		logic        bad_count;
	} rsp_t;

	// control that travels with each item through the multiplier
	typedef struct packed {
		logic       valid;
		logic [2:0] op;
		logic [7:0] rem;
		logic       bad;
		logic       loop;
	} tag_t;

endpackage

/* design/fcalu_if.sv */
// ----------------------------------------------------------------------------
// fcalu_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface fcalu_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/curve25519_field_alu.sv */
// ----------------------------------------------------------------------------
// curve25519_field_alu
// Field ALU for GF(2^255-19) in radix 2^51: multiply, repeated square, add,
// subtract, negate and canonical reduce.
//
//   channel  dir  payload
//   req      in   op, a_limb0..4, b_limb0..4, square_count
//   rsp      out  r_limb0..4, bad_count
//
// A request beat's accept edge loads the first of 8 multiplier stages and the
// output register follows the last. All ops except a multi-pass square issue
// one per cycle while the response is not stalled. A square with count n > 1
// passes the 8-stage multiplier n times and holds off new requests until its
// last pass leaves. Reset clears valid and loop control only. A stalled
// response freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module curve25519_field_alu (
	input  logic     clk,
	input  logic     arst_n,
	fcalu_if.sink    req,
	fcalu_if.source  rsp
);
	import fcalu_pkg::*;

	localparam int LIN_DLY = 5;

	logic    en;
	logic    busy_q;
	logic    out_valid_q;
	rsp_t    out_data_q;
	logic    accept;
	logic    recirc;
	tag_t    tag_in, tag_out;
	fe_in_t  a_in, b_in, x_in, y_in;
	fe_out_t mul_r, lin_r;
	fe_out_t lin_d_s [LIN_DLY];
	fe_out_t sel_r;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en && !busy_q;
	assign accept    = req.valid && req.ready;

	assign a_in = {req.data.a_limb4, req.data.a_limb3, req.data.a_limb2,
		req.data.a_limb1, req.data.a_limb0};
	assign b_in = {req.data.b_limb4, req.data.b_limb3, req.data.b_limb2,
		req.data.b_limb1, req.data.b_limb0};

	// loop a square item back for another pass
	assign recirc = tag_out.valid && tag_out.op == OP_SQR && !tag_out.bad
		&& tag_out.rem > 8'd1;

	// pick the multiplier entry: loop-back or new beat
	always_comb begin
		if (recirc) begin
			for (int i = 0; i < 5; i++) x_in[i] = mul_r[i][53:0];
			y_in         = x_in;
			tag_in       = tag_out;
			tag_in.rem   = tag_out.rem - 8'd1;
		end else begin
			x_in         = a_in;
			y_in         = (req.data.op == OP_SQR) ? a_in : b_in;
			tag_in.valid = accept;
			tag_in.op    = req.data.op;
			tag_in.rem   = req.data.square_count;
			tag_in.bad   = req.data.op == OP_SQR && req.data.square_count == 8'd0;
			tag_in.loop  = req.data.op == OP_SQR && req.data.square_count > 8'd1;
		end
	end

	fcalu_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_in),
		.x       (x_in),
		.y       (y_in),
		.tag_out (tag_out),
		.r       (mul_r)
	);

	fcalu_lin u_lin (
		.clk (clk),
		.en  (en),
		.op  (req.data.op),
		.bad (req.data.op == OP_SQR && req.data.square_count == 8'd0),
		.a   (a_in),
		.b   (b_in),
		.res (lin_r)
	);

	// delay the linear result to line up with the multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			lin_d_s[0] <= lin_r;
			for (int k = 1; k < LIN_DLY; k++) lin_d_s[k] <= lin_d_s[k - 1];
		end
	end

	// hold off requests while a square loops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && tag_in.loop) begin
			busy_q <= 1'b1;
		end else if (en && tag_out.valid && tag_out.loop && !recirc) begin
			busy_q <= 1'b0;
		end
	end

	assign sel_r = (tag_out.op == OP_MUL || (tag_out.op == OP_SQR && !tag_out.bad))
		? mul_r : lin_d_s[LIN_DLY - 1];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tag_out.valid && !recirc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {sel_r[0], sel_r[1], sel_r[2], sel_r[3], sel_r[4], tag_out.bad};
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("request taken while a square loops");

	a_recirc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		recirc |-> busy_q)
		else $error("loop-back without a looping square");

	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(accept))
		else $error("loop busy set without a request beat");

endmodule

/* design/fcalu_mul.sv */
// ----------------------------------------------------------------------------
// fcalu_mul
// Eight-stage field multiplier: partial products, product assembly, column
// sums, four carry stages, and the top-carry fold by 19.
// ----------------------------------------------------------------------------
module fcalu_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  fcalu_pkg::tag_t   tag_in,
	input  fcalu_pkg::fe_in_t x,
	input  fcalu_pkg::fe_in_t y,
	output fcalu_pkg::tag_t   tag_out,
	output fcalu_pkg::fe_out_t r
);
	import fcalu_pkg::*;

	logic [4:0][4:0][58:0]       m;
	logic [4:0][4:0][3:0][56:0]  pp_s1;
	logic [4:0][4:0][3:0][56:0]  pp_n;
	logic [4:0][4:0][PROD_W-1:0] prod_s2;
	logic [4:0][4:0][PROD_W-1:0] prod_n;
	col_t                        col_s3, col_n;
	col_t                        col_s4, col_s5, col_s6, col_s7;
	logic [63:0]                 top;
	logic [63:0]                 r0w;
	fe_out_t                     r_n, r_s8;
	tag_t                        tag_s [8];

	function automatic col_t carry_step(col_t c, int k);
		col_t o;
		o = c;
		o[k + 1] = c[k + 1] + (c[k] >> LIMB_BITS);
		return o;
	endfunction

	// select plain or 19-scaled multiplicand, split into partial products
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				m[i][j] = (i + j >= 5) ? 59'(y[j]) * 59'(FOLD) : 59'(y[j]);
				pp_n[i][j][0] = x[i][26:0]  * m[i][j][29:0];
				pp_n[i][j][1] = x[i][53:27] * m[i][j][29:0];
				pp_n[i][j][2] = x[i][26:0]  * m[i][j][58:30];
				pp_n[i][j][3] = x[i][53:27] * m[i][j][58:30];
			end
		end
	end

	// assemble full products
	always_comb begin
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				prod_n[i][j] = PROD_W'(pp_s1[i][j][0])
					+ (PROD_W'(pp_s1[i][j][1]) << 27)
					+ (PROD_W'(pp_s1[i][j][2]) << 30)
					+ (PROD_W'(pp_s1[i][j][3]) << 57);
			end
		end
	end

	// sum products into their columns
	always_comb begin
		col_n = '0;
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				col_n[(i + j) % 5] = col_n[(i + j) % 5] + COL_W'(prod_s2[i][j]);
			end
		end
	end

	// fold the top carry back with 19
	always_comb begin
		top = col_s7[4][114:51];
		r0w = 64'(col_s7[0][50:0]) + top * 64'(FOLD);
		r_n[0] = 55'(r0w[50:0]);
		r_n[1] = 55'(col_s7[1][50:0]) + 55'(r0w[63:51]);
		r_n[2] = 55'(col_s7[2][50:0]);
		r_n[3] = 55'(col_s7[3][50:0]);
		r_n[4] = 55'(col_s7[4][50:0]);
	end

	// advance datapath
	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1   <= pp_n;
			prod_s2 <= prod_n;
			col_s3  <= col_n;
			col_s4  <= carry_step(col_s3, 0);
			col_s5  <= carry_step(col_s4, 1);
			col_s6  <= carry_step(col_s5, 2);
			col_s7  <= carry_step(col_s6, 3);
			r_s8    <= r_n;
		end
	end

	// advance tags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) tag_s[k] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_in;
			for (int k = 1; k < 8; k++) tag_s[k] <= tag_s[k - 1];
		end
	end

	assign tag_out = tag_s[7];
	assign r       = r_s8;

endmodule

/* design/fcalu_lin.sv */
// ----------------------------------------------------------------------------
// fcalu_lin
// Three-stage path for add, subtract, negate, canonical reduce and the
// zero-count square pass-through.
// ----------------------------------------------------------------------------
module fcalu_lin (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         op,
	input  logic               bad,
	input  fcalu_pkg::fe_in_t  a,
	input  fcalu_pkg::fe_in_t  b,
	output fcalu_pkg::fe_out_t res
);
	import fcalu_pkg::*;

	logic [4:0][56:0] v;
	logic [4:0][5:0]  kv;
	logic [4:0][2:0]  ka;
	fe_out_t          res_n, res_s1, res_s2, res_s3, fin_n;
	logic [4:0][51:0] w_n, w_s1, w_s2;
	logic [2:0]       op_s1, op_s2;
	logic [1:0]       q_n, q_s2;
	logic [52:0]      t;

	// linear ops and the first weak reduce of the canonical path
	always_comb begin
		res_n = '0;
		for (int i = 0; i < 5; i++) begin
			v[i] = (op == OP_SUB)
				? 57'(a[i]) + 57'((i == 0) ? BIAS0 : BIASN) - 57'(b[i])
				: 57'((i == 0) ? BIAS0 : BIASN) - 57'(a[i]);
			kv[i] = v[i][56:51];
			ka[i] = a[i][53:51];
		end
		if (op inside {OP_SUB, OP_NEG}) begin
			res_n[0] = 55'(v[0][50:0]) + 55'(kv[4]) * 55'(FOLD);
			for (int i = 1; i < 5; i++) res_n[i] = 55'(v[i][50:0]) + 55'(kv[i - 1]);
		end else if (op == OP_ADD) begin
			for (int i = 0; i < 5; i++) res_n[i] = 55'(a[i]) + 55'(b[i]);
		end else if (op == OP_SQR && bad) begin
			for (int i = 0; i < 5; i++) res_n[i] = 55'(a[i]);
		end
		w_n[0] = 52'(a[0][50:0]) + 52'(ka[4]) * 52'(FOLD);
		for (int i = 1; i < 5; i++) w_n[i] = 52'(a[i][50:0]) + 52'(ka[i - 1]);
	end

	// find the quotient by p
	always_comb begin
		t   = 53'(w_s1[0]) + 53'(FOLD);
		q_n = t[52:51];
		for (int i = 1; i < 5; i++) begin
			t   = 53'(w_s1[i]) + 53'(q_n);
			q_n = t[52:51];
		end
	end

	// subtract q*p and propagate carries
	always_comb begin
		for (int i = 0; i < 5; i++) fin_n[i] = 55'(w_s2[i]);
		fin_n[0] = fin_n[0] + 55'(q_s2) * 55'(FOLD);
		for (int i = 0; i < 4; i++) begin
			fin_n[i + 1] = fin_n[i + 1] + (fin_n[i] >> LIMB_BITS);
			fin_n[i]     = fin_n[i] & 55'((56'd1 << LIMB_BITS) - 56'd1);
		end
		fin_n[4] = fin_n[4] & 55'((56'd1 << LIMB_BITS) - 56'd1);
	end

	// advance stages
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op;
			res_s1 <= res_n;
			w_s1   <= w_n;
			op_s2  <= op_s1;
			res_s2 <= res_s1;
			w_s2   <= w_s1;
			q_s2   <= q_n;
			res_s3 <= (op_s2 == OP_CAN) ? fin_n : res_s2;
		end
	end

	assign res = res_s3;

endmodule

/* dv/curve25519_field_alu_tb.sv */
// ----------------------------------------------------------------------------
// curve25519_field_alu_tb
// Self-checking bench for the GF(2^255-19) field ALU. Random and directed
// beats go into the request channel under varied idling on both sides. A
// scoreboard predicts each response with 128-bit column arithmetic and
// checks responses in order, field by field.
// ----------------------------------------------------------------------------
module curve25519_field_alu_tb;
	import fcalu_pkg::*;

	localparam int          N_RANDOM  = 2000;
	localparam longint      CYCLE_CAP = 3000000;
	localparam logic [50:0] LMASK     = {51{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycle_cnt = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_rsp = 1'b0;

	fcalu_if #(.T(req_t)) req();
	fcalu_if #(.T(rsp_t)) rsp();

	curve25519_field_alu dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	typedef logic [4:0][63:0] lanes_t;

	// field predictor: multiply with fold by 19
	function automatic lanes_t fmul(lanes_t x, lanes_t y);
		logic [4:0][127:0] col;
		logic [127:0] carry;
		logic [63:0] yj, top;
		lanes_t r;
		int k;
		col = '0;
		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 5; j++) begin
				k = i + j;
				yj = y[j];
				if (k >= 5) begin
					k -= 5;
					yj = yj * 64'd19;
				end
				col[k] += 128'(x[i]) * 128'(yj);
			end
		end
		for (int i = 0; i < 4; i++) begin
			col[i+1] += col[i] >> 51;
			r[i] = 64'(col[i][50:0]);
		end
		carry = col[4] >> 51;
		top = carry[63:0];
		r[4] = 64'(col[4][50:0]);
		r[0] = r[0] + top * 64'd19;
		r[1] += r[0] >> 51;
		r[0] &= 64'(LMASK);
		return r;
	endfunction

	function automatic lanes_t weak_fold(lanes_t v);
		lanes_t r;
		for (int i = 0; i < 5; i++)
			r[i] = (v[i] & 64'(LMASK)) + ((i == 0) ? (v[4] >> 51) * 64'd19 : v[i-1] >> 51);
		return r;
	endfunction

	function automatic rsp_t predict_field_op(req_t q);
		lanes_t a, b, r, v;
		logic [63:0] qq;
		rsp_t o;
		a = '{64'(q.a_limb4), 64'(q.a_limb3), 64'(q.a_limb2), 64'(q.a_limb1),
			64'(q.a_limb0)};
		b = '{64'(q.b_limb4), 64'(q.b_limb3), 64'(q.b_limb2), 64'(q.b_limb1),
			64'(q.b_limb0)};
		r = '0;
		o = '0;
		case (q.op)
			OP_MUL: r = fmul(a, b);
			OP_SQR: begin
				if (q.square_count == 0) begin
					r = a;
					o.bad_count = 1'b1;
				end else begin
					r = a;
					for (int n = 0; n < q.square_count; n++) r = fmul(r, r);
				end
			end
			OP_ADD: for (int i = 0; i < 5; i++) r[i] = a[i] + b[i];
			OP_SUB, OP_NEG: begin
				for (int i = 0; i < 5; i++)
					v[i] = (q.op == OP_SUB) ?
						(a[i] + 64'((i == 0) ? BIAS0 : BIASN)) - b[i] :
						64'((i == 0) ? BIAS0 : BIASN) - a[i];
				r = weak_fold(v);
			end
			OP_CAN: begin
				r = weak_fold(a);
				qq = (r[0] + 64'd19) >> 51;
				for (int i = 1; i < 5; i++) qq = (r[i] + qq) >> 51;
				r[0] += 64'd19 * qq;
				for (int i = 0; i < 4; i++) begin
					r[i+1] += r[i] >> 51;
					r[i] &= 64'(LMASK);
				end
				r[4] &= 64'(LMASK);
			end
			default: r = '0;
		endcase
		o.r_limb0 = r[0][54:0];
		o.r_limb1 = r[1][54:0];
		o.r_limb2 = r[2][54:0];
		o.r_limb3 = r[3][54:0];
		o.r_limb4 = r[4][54:0];
		return o;
	endfunction

	class field_scoreboard;
		rsp_t pending[$];
		int errors = 0;
		int checked = 0;
		int ops_seen[8];

		function void note_request(req_t q);
			pending.push_back(predict_field_op(q));
			ops_seen[q.op]++;
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t: response with nothing outstanding: %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.r_limb0 !== want.r_limb0)
				$display("%0t: r_limb0 exp %h got %h", $time, want.r_limb0, got.r_limb0);
			if (got.r_limb1 !== want.r_limb1)
				$display("%0t: r_limb1 exp %h got %h", $time, want.r_limb1, got.r_limb1);
			if (got.r_limb2 !== want.r_limb2)
				$display("%0t: r_limb2 exp %h got %h", $time, want.r_limb2, got.r_limb2);
			if (got.r_limb3 !== want.r_limb3)
				$display("%0t: r_limb3 exp %h got %h", $time, want.r_limb3, got.r_limb3);
			if (got.r_limb4 !== want.r_limb4)
				$display("%0t: r_limb4 exp %h got %h", $time, want.r_limb4, got.r_limb4);
			if (got.bad_count !== want.bad_count)
				$display("%0t: bad_count exp %b got %b", $time, want.bad_count,
					got.bad_count);
			if (got !== want) errors++;
		endfunction
	endclass

	field_scoreboard sb = new();

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("curve25519_field_alu_tb: FAIL");
			$finish;
		end
	end

	// receive side: sample beats, randomize ready
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) sb.check_response(rsp.data);
		rsp.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [53:0] rand_limb();
		case ($urandom_range(5))
			0: return '0;
			1: return {54{1'b1}};
			2: return {3'b0, {51{1'b1}}};
			3: return 54'($urandom());
			default: return 54'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t q;
		q.op = 3'($urandom_range(7));
		if ($urandom_range(9) == 0) q.op = OP_SQR;
		q.a_limb0 = rand_limb();
		q.a_limb1 = rand_limb();
		q.a_limb2 = rand_limb();
		q.a_limb3 = rand_limb();
		q.a_limb4 = rand_limb();
		q.b_limb0 = rand_limb();
		q.b_limb1 = rand_limb();
		q.b_limb2 = rand_limb();
		q.b_limb3 = rand_limb();
		q.b_limb4 = rand_limb();
		// mostly short squaring chains, a few long ones
		case ($urandom_range(19))
			0: q.square_count = 8'd255;
			1: q.square_count = 8'($urandom());
			2: q.square_count = 8'd0;
			default: q.square_count = 8'($urandom_range(1, 4));
		endcase
		return q;
	endfunction

	// offer one beat and wait for it to be taken; valid stays up afterwards
	task automatic send_beat(req_t q);
		while (($urandom_range(99) < idle_pct)) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= q;
		do @(posedge clk); while (!req.ready);
		sb.note_request(q);
	endtask

	// drop valid after the last beat of a burst
	task automatic release_req();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic req_t fill_req(logic [2:0] op, logic [53:0] av, logic [53:0] bv,
		logic [7:0] cnt);
		req_t q;
		q = '{op, av, av, av, av, av, bv, bv, bv, bv, bv, cnt};
		return q;
	endfunction

	initial begin
		req_t q;
		int phase;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every op, zero count, unused selectors
		for (int o = 0; o < 8; o++) begin
			send_beat(fill_req(3'(o), {54{1'b1}}, {54{1'b1}}, 8'd1));
			send_beat(fill_req(3'(o), '0, {54{1'b1}}, 8'd2));
		end
		send_beat(fill_req(OP_SQR, {54{1'b1}}, '0, 8'd0));
		send_beat(fill_req(OP_SQR, 54'd12345, '0, 8'd255));
		// p itself and p+1 for canonical reduce
		q = fill_req(OP_CAN, {3'b0, {51{1'b1}}}, '0, 8'd1);
		q.a_limb0 = {3'b0, LMASK} - 54'd18;
		send_beat(q);
		q.a_limb0 = q.a_limb0 + 54'd1;
		send_beat(q);
		send_beat(fill_req(OP_SUB, '0, {54{1'b1}}, 8'd1));
		release_req();
		drain();

		// long receiver hold-off while the sender keeps offering beats
		fork
			begin
				hold_rsp = 1'b1;
				repeat (60) @(posedge clk);
				hold_rsp = 1'b0;
			end
			for (int i = 0; i < 24; i++)
				send_beat(fill_req(OP_ADD, rand_limb(), rand_limb(), 8'd1));
		join
		release_req();
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			phase = (i * 4) / N_RANDOM;
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 58; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 58; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			send_beat(rand_req());
		end
		release_req();
		drain();
		repeat (40) @(posedge clk);

		$display("Checked %0d responses; ops mul %0d sqr %0d add %0d sub %0d neg %0d can %0d",
			sb.checked, sb.ops_seen[0], sb.ops_seen[1], sb.ops_seen[2], sb.ops_seen[3],
			sb.ops_seen[4], sb.ops_seen[5]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("curve25519_field_alu_tb: PASS");
		else
			$display("curve25519_field_alu_tb: FAIL");
		$finish;
	end
endmodule

/* curve25519_field_alu.f */
design/fcalu_pkg.sv
design/fcalu_if.sv
design/fcalu_mul.sv
design/fcalu_lin.sv
design/curve25519_field_alu.sv
dv/curve25519_field_alu_tb.sv
